[hdl/clu_pkg.sv]
// ----------------------------------------------------------------------------
// clu_pkg
// Shared types and constants of the cluster-label union-find engine.
// ----------------------------------------------------------------------------
package clu_pkg;

  localparam int LABEL_W    = 10;
  localparam int MAX_LABELS = 1024;
  localparam int TBL_DEPTH  = 1 << LABEL_W;
  localparam int LIMIT_INT  = (MAX_LABELS - 1) < (TBL_DEPTH - 1) ?
                              (MAX_LABELS - 1) : (TBL_DEPTH - 1);
  localparam logic [LABEL_W-1:0] LABEL_LIMIT = LIMIT_INT[LABEL_W-1:0];

  // action codes
  localparam logic [2:0] ACT_MAKE    = 3'd0;
  localparam logic [2:0] ACT_UNION   = 3'd1;
  localparam logic [2:0] ACT_FIND    = 3'd2;
  localparam logic [2:0] ACT_RESOLVE = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MAKE,
    OP_FULL,
    OP_BAD,
    OP_CLEAR,
    OP_ZERO,
    OP_SEEK_A,
    OP_SEEK_B,
    OP_WALK,
    OP_COMP_INIT,
    OP_COMP,
    OP_LINK,
    OP_ROOT_RES,
    OP_SMAP_RD,
    OP_SMAP_CHK,
    OP_FLAGS
  } dp_op_e;

  typedef struct packed {
    logic [2:0] act;
    logic       a_ok;
    logic       b_ok;
    logic       full;
    logic       walk_done;
    logic       comp_done;
    logic       out_busy;
  } dp_stat_t;

endpackage

[hdl/cluster_label_union_find.sv]
// ----------------------------------------------------------------------------
// cluster_label_union_find
// Union-find label equivalence engine for cluster labeling.
// ----------------------------------------------------------------------------
// One transaction at a time, one result per transaction. Make set, clear,
// unknown actions and rejected labels are handled in the dispatch state
// after the transaction is captured, and their result is then registered.
// Find walks the parent links from the label to its root and then
// compresses that chain; union walks and compresses two chains, and resolve
// adds the id lookup and mark update to find.
// A walk is paced by the single read port of the parent memory, which
// follows one link per cycle. A new transaction is taken while a result
// waits in the output register. No clearing pass is needed after reset or
// clear: table entries are rewritten as labels and ids are allocated.
// ----------------------------------------------------------------------------
module cluster_label_union_find import clu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // label_a[9:0], label_b[19:10], at_inlet[20],
                                      // at_outlet[21], zero[23:22]
  input  logic [2:0]  s_axis_tuser,   // action[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // label[9:0], new_cluster[10], inlet_mark[11],
                                      // outlet_mark[12], zero[15:13]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  dp_stat_t           stat;
  dp_op_e             op;
  logic [LABEL_W-1:0] label;
  logic               new_cluster, inlet_mark, outlet_mark;

  clu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .op_o       (op)
  );

  clu_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .action_i      (s_axis_tuser),
    .label_a_i     (s_axis_tdata[9:0]),
    .label_b_i     (s_axis_tdata[19:10]),
    .at_inlet_i    (s_axis_tdata[20]),
    .at_outlet_i   (s_axis_tdata[21]),
    .out_ready_i   (m_axis_tready),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid),
    .label_o       (label),
    .new_cluster_o (new_cluster),
    .inlet_mark_o  (inlet_mark),
    .outlet_mark_o (outlet_mark),
    .status_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, outlet_mark, inlet_mark, new_cluster, label};

endmodule

[hdl/clu_ram.sv]
// ----------------------------------------------------------------------------
// clu_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module clu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/clu_dpath.sv]
// ----------------------------------------------------------------------------
// clu_dpath
// Datapath: parent, sequence-map and cluster-flag memories, walk registers,
// counters and the result register.
// ----------------------------------------------------------------------------
module clu_dpath import clu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_op_e             op_i,
  input  logic [2:0]         action_i,
  input  logic [LABEL_W-1:0] label_a_i,
  input  logic [LABEL_W-1:0] label_b_i,
  input  logic               at_inlet_i,
  input  logic               at_outlet_i,
  input  logic               out_ready_i,
  output dp_stat_t           stat_o,
  output logic               out_valid_o,
  output logic [LABEL_W-1:0] label_o,
  output logic               new_cluster_o,
  output logic               inlet_mark_o,
  output logic               outlet_mark_o,
  output logic [1:0]         status_o
);

  localparam int AW = $clog2(TBL_DEPTH);

  // captured transaction
  logic [2:0]         act_q, act_d;
  logic [LABEL_W-1:0] a_q, a_d, b_q, b_d;
  logic               inl_q, inl_d, outl_q, outl_d;
  // walk state
  logic [LABEL_W-1:0] cur_q, cur_d, start_q, start_d, root_q, root_d, rb_q, rb_d;
  logic [LABEL_W-1:0] id_q, id_d;
  logic               fresh_q, fresh_d;
  // counters
  logic [LABEL_W-1:0] lc_q, lc_d, sc_q, sc_d;
  // result register
  logic               ov_q, ov_d;
  logic [LABEL_W-1:0] ol_q, ol_d;
  logic               of_q, of_d, oi_q, oi_d, oo_q, oo_d;
  logic [1:0]         os_q, os_d;

  // memory ports
  logic               par_we, smap_we, flg_we;
  logic [AW-1:0]      par_waddr, par_raddr, smap_waddr, smap_raddr, flg_waddr, flg_raddr;
  logic [LABEL_W-1:0] par_wdata, par_rdata, smap_wdata, smap_rdata;
  logic [1:0]         flg_wdata, flg_rdata;

  logic               res_en;
  logic [LABEL_W-1:0] res_label;
  logic               res_fresh, res_in, res_out;
  logic [1:0]         res_status;

  logic [LABEL_W-1:0] new_label, id_sel;
  logic [1:0]         flg_new;

  clu_ram #(.WIDTH(LABEL_W), .DEPTH(TBL_DEPTH)) u_parent (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  clu_ram #(.WIDTH(LABEL_W), .DEPTH(TBL_DEPTH)) u_seqmap (
    .clk_i   (clk_i),
    .we_i    (smap_we),
    .waddr_i (smap_waddr),
    .wdata_i (smap_wdata),
    .raddr_i (smap_raddr),
    .rdata_o (smap_rdata)
  );

  // bit 0 inlet, bit 1 outlet, indexed by sequential id
  clu_ram #(.WIDTH(2), .DEPTH(TBL_DEPTH)) u_flags (
    .clk_i   (clk_i),
    .we_i    (flg_we),
    .waddr_i (flg_waddr),
    .wdata_i (flg_wdata),
    .raddr_i (flg_raddr),
    .rdata_o (flg_rdata)
  );

  assign new_label = lc_q + LABEL_W'(1);

  always_comb begin
    act_d = act_q; a_d = a_q; b_d = b_q; inl_d = inl_q; outl_d = outl_q;
    cur_d = cur_q; start_d = start_q; root_d = root_q; rb_d = rb_q;
    id_d = id_q; fresh_d = fresh_q;
    lc_d = lc_q; sc_d = sc_q;
    id_sel = '0;
    flg_new = '0;

    par_we = 1'b0; par_waddr = cur_q; par_wdata = root_q; par_raddr = cur_q;
    smap_we = 1'b0; smap_waddr = root_q; smap_wdata = '0; smap_raddr = root_q;
    flg_we = 1'b0; flg_waddr = id_q; flg_wdata = '0; flg_raddr = id_q;

    res_en = 1'b0; res_label = '0; res_fresh = 1'b0; res_in = 1'b0; res_out = 1'b0;
    res_status = ST_OK;

    case (op_i)
      OP_LOAD: begin
        act_d = action_i; a_d = label_a_i; b_d = label_b_i;
        inl_d = at_inlet_i; outl_d = at_outlet_i;
      end
      OP_MAKE: begin
        // new label is its own root and has no sequential id yet
        par_we = 1'b1; par_waddr = new_label; par_wdata = new_label;
        smap_we = 1'b1; smap_waddr = new_label; smap_wdata = '0;
        lc_d = new_label;
        res_en = 1'b1; res_label = new_label;
      end
      OP_FULL: begin
        res_en = 1'b1; res_status = ST_FULL;
      end
      OP_BAD: begin
        res_en = 1'b1; res_status = ST_BAD;
      end
      OP_CLEAR: begin
        lc_d = '0; sc_d = '0;
        res_en = 1'b1;
      end
      OP_ZERO: begin
        res_en = 1'b1;
      end
      OP_SEEK_A: begin
        rb_d = root_q;
        cur_d = a_q; start_d = a_q; par_raddr = a_q;
      end
      OP_SEEK_B: begin
        cur_d = b_q; start_d = b_q; par_raddr = b_q;
      end
      OP_WALK: begin
        if (par_rdata == cur_q) begin
          root_d = cur_q;
        end else begin
          cur_d = par_rdata; par_raddr = par_rdata;
        end
      end
      OP_COMP_INIT: begin
        cur_d = start_q; par_raddr = start_q;
      end
      OP_COMP: begin
        // point cur at the root and step to its old parent
        if (cur_q != root_q) begin
          par_we = 1'b1; par_waddr = cur_q; par_wdata = root_q;
          cur_d = par_rdata; par_raddr = par_rdata;
        end
      end
      OP_LINK: begin
        par_we = 1'b1; par_waddr = rb_q; par_wdata = root_q;
        res_en = 1'b1; res_label = root_q;
      end
      OP_ROOT_RES: begin
        res_en = 1'b1; res_label = root_q;
      end
      OP_SMAP_RD: begin
        smap_raddr = root_q;
      end
      OP_SMAP_CHK: begin
        if (smap_rdata == '0) begin
          id_sel = sc_q + LABEL_W'(1);
          smap_we = 1'b1; smap_waddr = root_q; smap_wdata = id_sel;
          sc_d = id_sel;
          fresh_d = 1'b1;
        end else begin
          id_sel = smap_rdata;
          fresh_d = 1'b0;
        end
        id_d = id_sel;
        flg_raddr = id_sel;
      end
      OP_FLAGS: begin
        // a fresh id starts with clear marks
        flg_new = (fresh_q ? 2'b00 : flg_rdata) | {outl_q, inl_q};
        flg_we = 1'b1; flg_waddr = id_q; flg_wdata = flg_new;
        res_en = 1'b1; res_label = id_q; res_fresh = fresh_q;
        res_in = flg_new[0]; res_out = flg_new[1];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q; ol_d = ol_q; of_d = of_q; oi_d = oi_q; oo_d = oo_q; os_d = os_q;
    if (res_en) begin
      ov_d = 1'b1; ol_d = res_label; of_d = res_fresh;
      oi_d = res_in; oo_d = res_out; os_d = res_status;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= '0;
      sc_q <= '0;
      ov_q <= 1'b0;
    end else begin
      lc_q <= lc_d;
      sc_q <= sc_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; a_q <= a_d; b_q <= b_d; inl_q <= inl_d; outl_q <= outl_d;
    cur_q <= cur_d; start_q <= start_d; root_q <= root_d; rb_q <= rb_d;
    id_q <= id_d; fresh_q <= fresh_d;
    ol_q <= ol_d; of_q <= of_d; oi_q <= oi_d; oo_q <= oo_d; os_q <= os_d;
  end

  assign stat_o.act       = act_q;
  assign stat_o.a_ok      = (a_q != '0) && (a_q <= lc_q);
  assign stat_o.b_ok      = (b_q != '0) && (b_q <= lc_q);
  assign stat_o.full      = lc_q >= LABEL_LIMIT;
  assign stat_o.walk_done = par_rdata == cur_q;
  assign stat_o.comp_done = cur_q == root_q;
  assign stat_o.out_busy  = ov_q && !out_ready_i;

  assign out_valid_o   = ov_q;
  assign label_o       = ol_q;
  assign new_cluster_o = of_q;
  assign inlet_mark_o  = oi_q;
  assign outlet_mark_o = oo_q;
  assign status_o      = os_q;

endmodule

[hdl/clu_ctrl.sv]
// ----------------------------------------------------------------------------
// clu_ctrl
// Controller: sequences chain walks, path compression and table updates.
// ----------------------------------------------------------------------------
module clu_ctrl import clu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_CINIT = 4'd3;
  localparam logic [3:0] S_COMP  = 4'd4;
  localparam logic [3:0] S_LINK  = 4'd5;
  localparam logic [3:0] S_FRES  = 4'd6;
  localparam logic [3:0] S_SCHK  = 4'd7;
  localparam logic [3:0] S_FLAGS = 4'd8;

  logic [3:0] state_q, state_d;
  logic       phase_b_q, phase_b_d;  // union: walking label_b's chain

  always_comb begin
    state_d   = state_q;
    phase_b_d = phase_b_q;
    op_o      = OP_IDLE;
    in_ready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o = OP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.act)
          ACT_UNION: begin
            if (stat_i.a_ok && stat_i.b_ok) begin
              op_o = OP_SEEK_B; phase_b_d = 1'b1; state_d = S_WALK;
            end else if (!stat_i.out_busy) begin
              op_o = OP_BAD; state_d = S_IDLE;
            end
          end
          ACT_FIND, ACT_RESOLVE: begin
            if (stat_i.a_ok) begin
              op_o = OP_SEEK_A; phase_b_d = 1'b0; state_d = S_WALK;
            end else if (!stat_i.out_busy) begin
              op_o = OP_BAD; state_d = S_IDLE;
            end
          end
          ACT_MAKE: begin
            if (!stat_i.out_busy) begin
              op_o = stat_i.full ? OP_FULL : OP_MAKE; state_d = S_IDLE;
            end
          end
          ACT_CLEAR: begin
            if (!stat_i.out_busy) begin
              op_o = OP_CLEAR; state_d = S_IDLE;
            end
          end
          default: begin
            if (!stat_i.out_busy) begin
              op_o = OP_ZERO; state_d = S_IDLE;
            end
          end
        endcase
      end
      S_WALK: begin
        op_o = OP_WALK;
        if (stat_i.walk_done) begin
          state_d = S_CINIT;
        end
      end
      S_CINIT: begin
        op_o = OP_COMP_INIT;
        state_d = S_COMP;
      end
      S_COMP: begin
        if (!stat_i.comp_done) begin
          op_o = OP_COMP;
        end else if (stat_i.act == ACT_UNION) begin
          if (phase_b_q) begin
            // root of b is saved, now walk a
            op_o = OP_SEEK_A; phase_b_d = 1'b0; state_d = S_WALK;
          end else begin
            state_d = S_LINK;
          end
        end else if (stat_i.act == ACT_RESOLVE) begin
          op_o = OP_SMAP_RD; state_d = S_SCHK;
        end else begin
          state_d = S_FRES;
        end
      end
      S_LINK: begin
        if (!stat_i.out_busy) begin
          op_o = OP_LINK; state_d = S_IDLE;
        end
      end
      S_FRES: begin
        if (!stat_i.out_busy) begin
          op_o = OP_ROOT_RES; state_d = S_IDLE;
        end
      end
      S_SCHK: begin
        op_o = OP_SMAP_CHK;
        state_d = S_FLAGS;
      end
      S_FLAGS: begin
        if (!stat_i.out_busy) begin
          op_o = OP_FLAGS; state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_b_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_b_q <= phase_b_d;
    end
  end

endmodule
